FILE: hw/rtl/gld_pkg.sv
// Shared types and constants for the lockout debounce event block.
`timescale 1ns / 1ps
package gld_pkg;

   localparam int PIN_COUNT_DEFAULT = 32;
   localparam int TIME_BITS_DEFAULT = 48;

   localparam int SAMPLE_BITS    = 48;
   localparam int LEVEL_BITS     = 32;
   localparam int PIN_INDEX_BITS = 5;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 32;
   localparam int QUEUE_DEPTH    = 2;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_VALID_PINS     = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_INPUT_REQUEST  = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_OUTPUT_REQUEST = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LOCKOUT_TIME   = 2'd3;

   // one classified sample as it waits between front and back
   typedef struct packed {
      logic [SAMPLE_BITS-1:0] now;
      logic [LEVEL_BITS-1:0]  sampled;
   } item_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_SEEK,
      BK_CHECK,
      BK_FLUSH
   } back_state_type;

endpackage

FILE: hw/rtl/gpio_lockout_debounce_events_top.sv
// Per-pin lockout debouncer with event output: top level.
`timescale 1ns / 1ps
// Each beat on req_ carries a timestamp and the raw levels of all pins. The front masks
// the levels to the monitored pins and drops the sample into a two-entry queue; the back
// compares it with the stable levels and visits each changed pin in ascending order: a
// change-time memory read in BK_SEEK, then the lockout compare and update in BK_CHECK. A
// sample is loaded in BK_IDLE; if it caused events, its final event, which carries
// rsp_last_event, leaves in BK_FLUSH. An event waiting on rsp_ready stalls the next pin
// update and the final release. A sample with no accepted change yields no beat. Pin
// mask writes on csr_ apply to samples accepted afterwards, lockout writes to pins checked
// afterwards. Configuration writes are meant to be issued only while the block is idle.
module gpio_lockout_debounce_events_top #(
   parameter int PIN_COUNT = gld_pkg::PIN_COUNT_DEFAULT,
   parameter int TIME_BITS = gld_pkg::TIME_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [gld_pkg::SAMPLE_BITS-1:0]     req_sample_time,
   input  logic [gld_pkg::LEVEL_BITS-1:0]      req_pin_levels,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [gld_pkg::PIN_INDEX_BITS-1:0]  rsp_pin_index,
   output logic                                rsp_pressed,
   output logic                                rsp_last_event,
   input  logic                                csr_wr_en,
   input  logic [gld_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [gld_pkg::CSR_DATA_BITS-1:0]   csr_wr_data
);
   import gld_pkg::*;

   item_type                 front_item;
   item_type                 q_data;
   logic [CSR_DATA_BITS-1:0] lockout_time;
   logic                     q_full;
   logic                     q_valid;
   logic                     q_pop;
   logic                     q_push;

   assign req_ready = !q_full;
   assign q_push    = req_valid && !q_full;

   gld_front #(
      .PIN_COUNT (PIN_COUNT)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wr_data     (csr_wr_data),
      .req_sample_time (req_sample_time),
      .req_pin_levels  (req_pin_levels),
      .item            (front_item),
      .lockout_time    (lockout_time)
   );

   gld_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (front_item),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_valid),
      .pop_data  (q_data)
   );

   gld_back #(
      .PIN_COUNT (PIN_COUNT),
      .TIME_BITS (TIME_BITS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (q_valid),
      .q_data         (q_data),
      .q_pop          (q_pop),
      .lockout_time   (lockout_time),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_pin_index  (rsp_pin_index),
      .rsp_pressed    (rsp_pressed),
      .rsp_last_event (rsp_last_event)
   );

   // the back never takes from an empty queue
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("queue popped while empty");

   // events only name pins that exist
   a_pin_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ({1'b0, rsp_pin_index} < (PIN_INDEX_BITS+1)'(PIN_COUNT)))
      else $error("event for pin beyond pin count");

   // no event beat comes straight out of reset
   a_reset_quiet: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("event valid right after reset");

endmodule

FILE: hw/rtl/gld_front.sv
// Front end: configuration registers and masking of each sample to the monitored pins.
`timescale 1ns / 1ps
module gld_front #(
   parameter int PIN_COUNT = gld_pkg::PIN_COUNT_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [gld_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [gld_pkg::CSR_DATA_BITS-1:0]   csr_wr_data,
   input  logic [gld_pkg::SAMPLE_BITS-1:0]     req_sample_time,
   input  logic [gld_pkg::LEVEL_BITS-1:0]      req_pin_levels,
   output gld_pkg::item_type                   item,
   output logic [gld_pkg::CSR_DATA_BITS-1:0]   lockout_time
);
   import gld_pkg::*;

   localparam logic [LEVEL_BITS-1:0] PIN_MASK = {LEVEL_BITS{1'b1}} >> (LEVEL_BITS - PIN_COUNT);

   logic [LEVEL_BITS-1:0]    valid_pins_ff,  valid_pins_in;
   logic [LEVEL_BITS-1:0]    in_req_ff,      in_req_in;
   logic [LEVEL_BITS-1:0]    out_req_ff,     out_req_in;
   logic [CSR_DATA_BITS-1:0] lockout_ff,     lockout_in;
   logic [LEVEL_BITS-1:0]    outputs;
   logic [LEVEL_BITS-1:0]    monitored;

   always_comb begin
      valid_pins_in = valid_pins_ff;
      in_req_in     = in_req_ff;
      out_req_in    = out_req_ff;
      lockout_in    = lockout_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_VALID_PINS:     valid_pins_in = csr_wr_data;
            CSR_INPUT_REQUEST:  in_req_in     = csr_wr_data;
            CSR_OUTPUT_REQUEST: out_req_in    = csr_wr_data;
            CSR_LOCKOUT_TIME:   lockout_in    = csr_wr_data;
            default:            lockout_in    = lockout_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_pins_ff <= '0;
         in_req_ff     <= '0;
         out_req_ff    <= '0;
         lockout_ff    <= '0;
      end else begin
         valid_pins_ff <= valid_pins_in;
         in_req_ff     <= in_req_in;
         out_req_ff    <= out_req_in;
         lockout_ff    <= lockout_in;
      end
   end

   // input request wins over output request
   assign outputs   = out_req_ff & ~in_req_ff & valid_pins_ff;
   assign monitored = valid_pins_ff & ~outputs & PIN_MASK;

   assign item.now     = req_sample_time;
   assign item.sampled = req_pin_levels & monitored;
   assign lockout_time = lockout_ff;

endmodule

FILE: hw/rtl/gld_fifo.sv
// Short queue of classified samples between front and back.
`timescale 1ns / 1ps
module gld_fifo (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  gld_pkg::item_type  push_data,
   output logic               full,
   input  logic               pop,
   output logic               not_empty,
   output gld_pkg::item_type  pop_data
);
   import gld_pkg::*;

   localparam int QAW = $clog2(QUEUE_DEPTH);

   item_type         slots [QUEUE_DEPTH];
   logic [QAW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QAW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QAW:0]     count_ff,  count_in;

   assign full      = (count_ff == (QAW+1)'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_data  = slots[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: hw/rtl/gld_back.sv
// Back end: walks the changed pins of one sample, applies lockout, emits events.
`timescale 1ns / 1ps
module gld_back #(
   parameter int PIN_COUNT = gld_pkg::PIN_COUNT_DEFAULT,
   parameter int TIME_BITS = gld_pkg::TIME_BITS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 q_valid,
   input  gld_pkg::item_type                    q_data,
   output logic                                 q_pop,
   input  logic [gld_pkg::CSR_DATA_BITS-1:0]    lockout_time,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [gld_pkg::PIN_INDEX_BITS-1:0]   rsp_pin_index,
   output logic                                 rsp_pressed,
   output logic                                 rsp_last_event
);
   import gld_pkg::*;

   localparam int TW        = (TIME_BITS < SAMPLE_BITS) ? TIME_BITS : SAMPLE_BITS;
   localparam int SW        = ((TW > CSR_DATA_BITS) ? TW : CSR_DATA_BITS) + 1;
   localparam int PW        = (PIN_COUNT > 1) ? $clog2(PIN_COUNT) : 1;
   localparam int MEM_DEPTH = 2 ** PW;
   localparam logic [LEVEL_BITS-1:0] PIN_MASK = {LEVEL_BITS{1'b1}} >> (LEVEL_BITS - PIN_COUNT);

   back_state_type            state_ff, state_in;
   logic [TW-1:0]             now_ff, now_in;
   logic [LEVEL_BITS-1:0]     samp_ff, samp_in;
   logic [LEVEL_BITS-1:0]     pend_ff, pend_in;
   logic [LEVEL_BITS-1:0]     stable_ff, stable_in;
   logic [PW-1:0]             pin_ff, pin_in;
   logic                      held_vld_ff, held_vld_in;
   logic [PW-1:0]             held_pin_ff, held_pin_in;
   logic                      held_prs_ff, held_prs_in;
   logic                      rsp_vld_ff, rsp_vld_in;
   logic [PIN_INDEX_BITS-1:0] rsp_pin_ff, rsp_pin_in;
   logic                      rsp_prs_ff, rsp_prs_in;
   logic                      rsp_last_ff, rsp_last_in;
   logic [MEM_DEPTH-1:0]      written_ff;
   logic                      rd_hit_ff;

   logic [TW-1:0]             times [MEM_DEPTH];
   logic [TW-1:0]             rd_data_ff;

   logic                      mem_re;
   logic                      mem_we;
   logic [PW-1:0]             first_pin;
   logic [TW-1:0]             last_change;
   logic                      passed;
   logic                      out_free;

   // lowest pending pin
   always_comb begin
      first_pin = '0;
      for (int i = PIN_COUNT - 1; i >= 0; i--) begin
         if (pend_ff[i]) begin
            first_pin = PW'(i);
         end
      end
   end

   // never-written entries read as the reset time of zero
   assign last_change = rd_hit_ff ? rd_data_ff : '0;
   assign passed      = (SW'(last_change) + SW'(lockout_time)) <= SW'(now_ff);
   assign out_free    = !rsp_vld_ff || rsp_ready;

   always_comb begin
      state_in    = state_ff;
      now_in      = now_ff;
      samp_in     = samp_ff;
      pend_in     = pend_ff;
      stable_in   = stable_ff;
      pin_in      = pin_ff;
      held_vld_in = held_vld_ff;
      held_pin_in = held_pin_ff;
      held_prs_in = held_prs_ff;
      rsp_vld_in  = rsp_vld_ff && !rsp_ready;
      rsp_pin_in  = rsp_pin_ff;
      rsp_prs_in  = rsp_prs_ff;
      rsp_last_in = rsp_last_ff;
      q_pop       = 1'b0;
      mem_re      = 1'b0;
      mem_we      = 1'b0;
      case (state_ff)
         BK_IDLE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               now_in   = q_data.now[TW-1:0];
               samp_in  = q_data.sampled;
               pend_in  = (stable_ff ^ q_data.sampled) & PIN_MASK;
               state_in = BK_SEEK;
            end
         end
         BK_SEEK: begin
            if (pend_ff == '0) begin
               state_in = held_vld_ff ? BK_FLUSH : BK_IDLE;
            end else begin
               mem_re   = 1'b1;
               pin_in   = first_pin;
               pend_in  = pend_ff & (pend_ff - 1'b1);
               state_in = BK_CHECK;
            end
         end
         BK_CHECK: begin
            if (!passed) begin
               state_in = BK_SEEK;
            end else if (!held_vld_ff || out_free) begin
               // a newer event exists, so the held one is not the last
               if (held_vld_ff) begin
                  rsp_vld_in  = 1'b1;
                  rsp_pin_in  = PIN_INDEX_BITS'(held_pin_ff);
                  rsp_prs_in  = held_prs_ff;
                  rsp_last_in = 1'b0;
               end
               held_vld_in = 1'b1;
               held_pin_in = pin_ff;
               held_prs_in = !samp_ff[pin_ff];
               stable_in   = stable_ff ^ (LEVEL_BITS'(1) << pin_ff);
               mem_we      = 1'b1;
               state_in    = BK_SEEK;
            end
         end
         BK_FLUSH: begin
            if (out_free) begin
               rsp_vld_in  = 1'b1;
               rsp_pin_in  = PIN_INDEX_BITS'(held_pin_ff);
               rsp_prs_in  = held_prs_ff;
               rsp_last_in = 1'b1;
               held_vld_in = 1'b0;
               state_in    = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= BK_IDLE;
         stable_ff   <= '0;
         held_vld_ff <= 1'b0;
         rsp_vld_ff  <= 1'b0;
         written_ff  <= '0;
         rd_hit_ff   <= 1'b0;
      end else begin
         state_ff    <= state_in;
         stable_ff   <= stable_in;
         held_vld_ff <= held_vld_in;
         rsp_vld_ff  <= rsp_vld_in;
         if (mem_we) begin
            written_ff[pin_ff] <= 1'b1;
         end
         if (mem_re) begin
            rd_hit_ff <= written_ff[first_pin];
         end
      end
   end

   always_ff @(posedge clock) begin
      now_ff      <= now_in;
      samp_ff     <= samp_in;
      pend_ff     <= pend_in;
      pin_ff      <= pin_in;
      held_pin_ff <= held_pin_in;
      held_prs_ff <= held_prs_in;
      rsp_pin_ff  <= rsp_pin_in;
      rsp_prs_ff  <= rsp_prs_in;
      rsp_last_ff <= rsp_last_in;
   end

   // change-time memory, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         times[pin_ff] <= now_ff;
      end
      if (mem_re) begin
         rd_data_ff <= times[first_pin];
      end
   end

   assign rsp_valid      = rsp_vld_ff;
   assign rsp_pin_index  = rsp_pin_ff;
   assign rsp_pressed    = rsp_prs_ff;
   assign rsp_last_event = rsp_last_ff;

endmodule
